[hdl/assert_macros.svh]
// Assertion helpers included by the admission unit. Each macro expects a clock named clk
// and an active-low reset named rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define MTA_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MTA_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mta_pkg.sv]
`default_nettype none

package mta_pkg;

  localparam int ID_W       = 64;
  localparam int BYTES_W    = 32;
  localparam int FAN_REG_W  = 7;
  localparam int BIDX_W     = 6;
  localparam int DROP_CNT_W = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int REASON_W   = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_FANOUT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_FANOUT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_BYTES  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_BYTES  = 4'd3;

  // Configuration reset values.
  localparam logic [FAN_REG_W-1:0] FANOUT_RST = 7'd64;
  localparam logic [BYTES_W-1:0]   BYTES_RST  = 32'hFFFF_FFFF;

  // Drop reason codes.
  localparam logic [REASON_W-1:0] R_NONE    = 4'd0;
  localparam logic [REASON_W-1:0] R_OFFLINE = 4'd1;
  localparam logic [REASON_W-1:0] R_INVALID = 4'd2;
  localparam logic [REASON_W-1:0] R_DUP     = 4'd3;
  localparam logic [REASON_W-1:0] R_FANOUT  = 4'd4;
  localparam logic [REASON_W-1:0] R_BYTES   = 4'd5;
  localparam logic [REASON_W-1:0] R_SOFT    = 4'd6;
  localparam logic [REASON_W-1:0] R_OWNER   = 4'd7;
  localparam logic [REASON_W-1:0] R_CLOSED  = 4'd8;
  localparam logic [REASON_W-1:0] R_FULL    = 4'd9;

  typedef struct packed {
    logic               first_of_plan;
    logic [BYTES_W-1:0] payload_bytes;
    logic               low_priority;
    logic               eligible;
    logic [ID_W-1:0]    session_id;
    logic               has_endpoint;
    logic [ID_W-1:0]    endpoint_id;
    logic               owner_available;
    logic [ID_W-1:0]    owner_id;
    logic               endpoint_open;
  } in_item_t;

  typedef struct packed {
    logic                  admitted;
    logic [REASON_W-1:0]   drop_reason;
    logic [ID_W-1:0]       reported_id;
    logic [BIDX_W-1:0]     batch_index;
    logic                  new_batch;
    logic [FAN_REG_W-1:0]  accepted_count;
    logic [DROP_CNT_W-1:0] dropped_count;
  } out_item_t;

  typedef struct packed {
    logic hard_over;
    logic soft_over;
  } budget_stat_t;

endpackage

`default_nettype wire

[hdl/mta_ram.sv]
`default_nettype none

// Simple dual-port memory: one write port, one registered read port.
module mta_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/mta_budget.sv]
`default_nettype none

// Byte budget check. The test payload > budget / slot is evaluated as
// payload * slot > budget, which is exact for unsigned integers. The product
// is registered on start and compared in the following cycle.
module mta_budget #(
  parameter int SLOT_W = 7
) (
  input  wire logic                          clk,
  input  wire logic                          start,
  input  wire logic [mta_pkg::BYTES_W-1:0]   payload,
  input  wire logic [SLOT_W-1:0]             slot,
  input  wire logic [mta_pkg::BYTES_W-1:0]   hard_bytes,
  input  wire logic [mta_pkg::BYTES_W-1:0]   soft_bytes,
  output mta_pkg::budget_stat_t              stat
);

  localparam int PROD_W = mta_pkg::BYTES_W + SLOT_W;

  logic [PROD_W-1:0] product_r;
  logic [PROD_W-1:0] product_nxt;

  assign product_nxt = PROD_W'(payload) * PROD_W'(slot);

  always_ff @(posedge clk) begin
    if (start) begin
      product_r <= product_nxt;
    end
  end

  assign stat.hard_over = product_r > PROD_W'(hard_bytes);
  assign stat.soft_over = product_r > PROD_W'(soft_bytes);

endmodule

`default_nettype wire

[hdl/multicast_target_admission_unit.sv]
// The time from acceptance to a valid result grows with the number of endpoint ids
//   already seen in the plan and with the number of open batches; drops and early owner
//   matches finish sooner. A new transaction is taken only once the last one has left
//   the sequencer; a finished result waits in the output register while the next input
//   is taken, and the sequencer holds if that register is full.
// Reset (rst_n low, synchronous) restores the limit registers and empties the plan state.
`default_nettype none

module multicast_target_admission_unit #(
  parameter int SEEN_DEPTH = 128,
  parameter int MAX_FANOUT = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input transactions, one target each.
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire mta_pkg::in_item_t               in_data,
  // Result transactions, one per input.
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output mta_pkg::out_item_t                   out_data,
  // Configuration writes.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mta_pkg::BYTES_W-1:0]     cfg_data
);

  `include "assert_macros.svh"

  localparam int SEEN_AW = $clog2(SEEN_DEPTH);
  localparam int SEEN_CW = $clog2(SEEN_DEPTH + 1);
  localparam int FAN_AW  = (MAX_FANOUT > 1) ? $clog2(MAX_FANOUT) : 1;
  localparam int FAN_CW  = $clog2(MAX_FANOUT + 1);
  localparam int SCAN_W  = (SEEN_CW > FAN_CW) ? SEEN_CW : FAN_CW;
  localparam int CMP_W   = (FAN_CW > mta_pkg::FAN_REG_W) ? FAN_CW : mta_pkg::FAN_REG_W;

  // The sequencer walks one transaction through these steps: early checks,
  // the duplicate scan over the seen ids, the budget checks, and the owner scan
  // that finds or opens a batch. The result then moves to the output register.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_SEEN,
    S_BUDGET,
    S_OWN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // Limit registers.
  logic [mta_pkg::FAN_REG_W-1:0] hard_fanout_r;
  logic [mta_pkg::FAN_REG_W-1:0] soft_fanout_r;
  logic [mta_pkg::BYTES_W-1:0]   hard_bytes_r;
  logic [mta_pkg::BYTES_W-1:0]   soft_bytes_r;

  // Plan state.
  mta_pkg::in_item_t              item_r, item_nxt;
  logic [SEEN_CW-1:0]             seen_count_r, seen_count_nxt;
  logic [FAN_CW-1:0]              batch_count_r, batch_count_nxt;
  logic [FAN_CW-1:0]              admitted_total_r, admitted_total_nxt;
  logic [mta_pkg::DROP_CNT_W-1:0] dropped_total_r, dropped_total_nxt;

  // Scan control: scan_r is the next address to read, cmp_vld_r marks that the
  // read data of address cmp_idx_r is present at the comparator this cycle.
  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic [SCAN_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;

  mta_pkg::out_item_t res_r, res_nxt;
  mta_pkg::out_item_t out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Memory ports.
  logic                    seen_we, seen_re;
  logic                    owner_we, owner_re;
  logic [mta_pkg::ID_W-1:0] seen_rdata, owner_rdata;

  // Shared comparator.
  logic [mta_pkg::ID_W-1:0] cmp_a, cmp_b;
  logic                     cmp_match;
  logic                     hit;

  // Budget unit.
  logic                  budget_start;
  logic [FAN_CW-1:0]     slot;
  mta_pkg::budget_stat_t bstat;

  logic seen_issue, own_issue;
  logic hard_fan_hit, soft_fan_hit;

  // Result assembly.
  logic                         finish;
  logic                         fin_adm;
  logic [mta_pkg::REASON_W-1:0] fin_reason;
  logic [mta_pkg::ID_W-1:0]     fin_id;
  logic [mta_pkg::BIDX_W-1:0]   fin_bidx;
  logic                         fin_nb;

  mta_ram #(
    .DEPTH (SEEN_DEPTH),
    .WIDTH (mta_pkg::ID_W)
  ) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_count_r[SEEN_AW-1:0]),
    .wdata (item_r.endpoint_id),
    .re    (seen_re),
    .raddr (scan_r[SEEN_AW-1:0]),
    .rdata (seen_rdata)
  );

  mta_ram #(
    .DEPTH (MAX_FANOUT),
    .WIDTH (mta_pkg::ID_W)
  ) u_owner_ram (
    .clk   (clk),
    .we    (owner_we),
    .waddr (batch_count_r[FAN_AW-1:0]),
    .wdata (item_r.owner_id),
    .re    (owner_re),
    .raddr (scan_r[FAN_AW-1:0]),
    .rdata (owner_rdata)
  );

  // The slot number is only used while fewer than MAX_FANOUT targets are
  // admitted, so it always fits the count width.
  assign slot = admitted_total_r + FAN_CW'(1);

  mta_budget #(
    .SLOT_W (FAN_CW)
  ) u_budget (
    .clk        (clk),
    .start      (budget_start),
    .payload    (item_r.payload_bytes),
    .slot       (slot),
    .hard_bytes (hard_bytes_r),
    .soft_bytes (soft_bytes_r),
    .stat       (bstat)
  );

  // One comparator serves both scans; the owner scan uses it in S_OWN only.
  assign cmp_a     = (state_r == S_OWN) ? owner_rdata : seen_rdata;
  assign cmp_b     = (state_r == S_OWN) ? item_r.owner_id : item_r.endpoint_id;
  assign cmp_match = (cmp_a == cmp_b);
  assign hit       = cmp_vld_r && cmp_match;

  assign seen_issue = scan_r < SCAN_W'(seen_count_r);
  assign own_issue  = scan_r < SCAN_W'(batch_count_r);

  // Fanout stops at the programmed limit and also at the batch store capacity.
  assign hard_fan_hit = (CMP_W'(admitted_total_r) >= CMP_W'(hard_fanout_r)) ||
                        (admitted_total_r >= FAN_CW'(MAX_FANOUT));
  assign soft_fan_hit = CMP_W'(admitted_total_r) >= CMP_W'(soft_fanout_r);

  always_comb begin
    state_nxt          = state_r;
    item_nxt           = item_r;
    seen_count_nxt     = seen_count_r;
    batch_count_nxt    = batch_count_r;
    admitted_total_nxt = admitted_total_r;
    dropped_total_nxt  = dropped_total_r;
    scan_nxt           = scan_r;
    cmp_idx_nxt        = scan_r;
    cmp_vld_nxt        = 1'b0;
    res_nxt            = res_r;
    out_data_nxt       = out_data_r;
    out_valid_nxt      = out_valid_r;
    seen_we            = 1'b0;
    seen_re            = 1'b0;
    owner_we           = 1'b0;
    owner_re           = 1'b0;
    budget_start       = 1'b0;
    finish             = 1'b0;
    fin_adm            = 1'b0;
    fin_reason         = mta_pkg::R_NONE;
    fin_id             = item_r.endpoint_id;
    fin_bidx           = '0;
    fin_nb             = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          // A new plan forgets every id, batch and count of the previous one.
          if (in_data.first_of_plan) begin
            seen_count_nxt     = '0;
            batch_count_nxt    = '0;
            admitted_total_nxt = '0;
            dropped_total_nxt  = '0;
          end
          state_nxt = S_PRE;
        end
      end

      S_PRE: begin
        if (!item_r.eligible) begin
          finish     = 1'b1;
          fin_reason = mta_pkg::R_OFFLINE;
          fin_id     = item_r.session_id;
        end else if (!item_r.has_endpoint) begin
          finish     = 1'b1;
          fin_reason = mta_pkg::R_INVALID;
          fin_id     = '0;
        end else begin
          scan_nxt  = '0;
          state_nxt = S_SEEN;
        end
      end

      S_SEEN: begin
        if (hit) begin
          finish     = 1'b1;
          fin_reason = mta_pkg::R_DUP;
        end else if (seen_issue) begin
          seen_re     = 1'b1;
          scan_nxt    = scan_r + SCAN_W'(1);
          cmp_vld_nxt = 1'b1;
        end else if (!cmp_vld_r) begin
          // Scan done without a match. The id is recorded before the later
          // checks, so it counts as seen even when the target is dropped.
          if (seen_count_r == SEEN_CW'(SEEN_DEPTH)) begin
            finish     = 1'b1;
            fin_reason = mta_pkg::R_FULL;
          end else begin
            seen_we        = 1'b1;
            seen_count_nxt = seen_count_r + SEEN_CW'(1);
            if (hard_fan_hit) begin
              finish     = 1'b1;
              fin_reason = mta_pkg::R_FANOUT;
            end else begin
              budget_start = 1'b1;
              state_nxt    = S_BUDGET;
            end
          end
        end
      end

      S_BUDGET: begin
        if (bstat.hard_over) begin
          finish     = 1'b1;
          fin_reason = mta_pkg::R_BYTES;
        end else if (item_r.low_priority && (soft_fan_hit || bstat.soft_over)) begin
          finish     = 1'b1;
          fin_reason = mta_pkg::R_SOFT;
        end else if (!item_r.owner_available) begin
          finish     = 1'b1;
          fin_reason = mta_pkg::R_OWNER;
        end else if (!item_r.endpoint_open) begin
          finish     = 1'b1;
          fin_reason = mta_pkg::R_CLOSED;
        end else begin
          scan_nxt  = '0;
          state_nxt = S_OWN;
        end
      end

      S_OWN: begin
        if (hit) begin
          finish   = 1'b1;
          fin_adm  = 1'b1;
          fin_bidx = mta_pkg::BIDX_W'(cmp_idx_r);
        end else if (own_issue) begin
          owner_re    = 1'b1;
          scan_nxt    = scan_r + SCAN_W'(1);
          cmp_vld_nxt = 1'b1;
        end else if (!cmp_vld_r) begin
          // Owner not found: open a new batch. A free slot always exists
          // because there are never more batches than admitted targets.
          owner_we        = 1'b1;
          batch_count_nxt = batch_count_r + FAN_CW'(1);
          finish          = 1'b1;
          fin_adm         = 1'b1;
          fin_bidx        = mta_pkg::BIDX_W'(batch_count_r);
          fin_nb          = 1'b1;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      if (fin_adm) begin
        admitted_total_nxt = admitted_total_r + FAN_CW'(1);
      end else if (!(&dropped_total_r)) begin
        dropped_total_nxt = dropped_total_r + mta_pkg::DROP_CNT_W'(1);
      end
      res_nxt.admitted       = fin_adm;
      res_nxt.drop_reason    = fin_reason;
      res_nxt.reported_id    = fin_id;
      res_nxt.batch_index    = fin_bidx;
      res_nxt.new_batch      = fin_nb;
      res_nxt.accepted_count = mta_pkg::FAN_REG_W'(admitted_total_nxt);
      res_nxt.dropped_count  = dropped_total_nxt;
      state_nxt              = S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      seen_count_r     <= '0;
      batch_count_r    <= '0;
      admitted_total_r <= '0;
      dropped_total_r  <= '0;
      cmp_vld_r        <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      item_r           <= item_nxt;
      seen_count_r     <= seen_count_nxt;
      batch_count_r    <= batch_count_nxt;
      admitted_total_r <= admitted_total_nxt;
      dropped_total_r  <= dropped_total_nxt;
      scan_r           <= scan_nxt;
      cmp_idx_r        <= cmp_idx_nxt;
      cmp_vld_r        <= cmp_vld_nxt;
      res_r            <= res_nxt;
      out_data_r       <= out_data_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Limit registers take a write in any cycle; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_fanout_r <= mta_pkg::FANOUT_RST;
      soft_fanout_r <= mta_pkg::FANOUT_RST;
      hard_bytes_r  <= mta_pkg::BYTES_RST;
      soft_bytes_r  <= mta_pkg::BYTES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        mta_pkg::CFG_HARD_FANOUT: hard_fanout_r <= cfg_data[mta_pkg::FAN_REG_W-1:0];
        mta_pkg::CFG_SOFT_FANOUT: soft_fanout_r <= cfg_data[mta_pkg::FAN_REG_W-1:0];
        mta_pkg::CFG_HARD_BYTES:  hard_bytes_r  <= cfg_data;
        mta_pkg::CFG_SOFT_BYTES:  soft_bytes_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MTA_CHECK(a_seen_bound, seen_count_r <= SEEN_CW'(SEEN_DEPTH), "seen id count above depth")
  `MTA_CHECK(a_batch_le_adm, batch_count_r <= admitted_total_r, "more batches than targets")
  `MTA_CHECK_NEXT(a_plan_clear,
    in_valid && in_ready && in_data.first_of_plan,
    admitted_total_r == '0 && batch_count_r == '0 && dropped_total_r == '0,
    "plan state not cleared")
  `MTA_CHECK(a_adm_reason,
    out_valid && out_data.admitted |-> out_data.drop_reason == mta_pkg::R_NONE,
    "admitted result with a drop reason")
  `MTA_CHECK(a_new_batch, out_valid && out_data.new_batch |-> out_data.admitted,
    "new batch on a dropped target")

endmodule

`default_nettype wire

[tb/multicast_target_admission_unit_tb.sv]
module multicast_target_admission_unit_tb;

  // The block is built with the sizes the predictor below assumes.
  localparam int SEEN_DEPTH = 128;
  localparam int MAX_FANOUT = 64;

  // Register indexes that map to no register. Writes to them must change nothing.
  localparam logic [mta_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST = 4'd4;
  localparam logic [mta_pkg::CFG_IDX_W-1:0] CFG_SPARE_LAST  = 4'd15;

  // Long enough for a full scan of both stores plus the output register.
  localparam int SETTLE_CYCLES = SEEN_DEPTH + MAX_FANOUT + 16;

  // Random transactions sent in each idling phase.
  localparam int RANDOM_PER_PHASE = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  mta_pkg::in_item_t in_data = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  mta_pkg::out_item_t out_data;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mta_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mta_pkg::BYTES_W-1:0] cfg_data = '0;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int idle_pct = 0;
  int stall_pct = 0;

  int mismatch_count = 0;

  // Admission results that the block still owes, oldest first.
  mta_pkg::out_item_t pending_results[$];

  // Limit registers as the predictor sees them, starting from their reset values.
  logic [mta_pkg::FAN_REG_W-1:0] lim_hard_fanout = mta_pkg::FANOUT_RST;
  logic [mta_pkg::FAN_REG_W-1:0] lim_soft_fanout = mta_pkg::FANOUT_RST;
  logic [mta_pkg::BYTES_W-1:0] lim_hard_bytes = mta_pkg::BYTES_RST;
  logic [mta_pkg::BYTES_W-1:0] lim_soft_bytes = mta_pkg::BYTES_RST;

  // Plan state of the predictor. Only entries below the counts are ever read,
  // so the stores need no clearing.
  logic [mta_pkg::ID_W-1:0] plan_ids[SEEN_DEPTH];
  int plan_id_count = 0;
  logic [mta_pkg::ID_W-1:0] batch_owner_ids[MAX_FANOUT];
  int batch_total = 0;
  logic [mta_pkg::FAN_REG_W-1:0] admit_total = '0;
  logic [mta_pkg::DROP_CNT_W-1:0] drop_total = '0;

  multicast_target_admission_unit #(
    .SEEN_DEPTH(SEEN_DEPTH),
    .MAX_FANOUT(MAX_FANOUT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random; with stall_pct at zero it always takes the result.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Works out the result of one target and advances the plan state. The checks run
  // in priority order. An endpoint id is recorded as soon as it passes the duplicate
  // check, so a target dropped by a later check still blocks its id for the plan.
  function automatic mta_pkg::out_item_t admit_target(input mta_pkg::in_item_t t);
    mta_pkg::out_item_t r;
    logic [mta_pkg::REASON_W-1:0] why;
    logic [63:0] slot;
    int hit;
    int i;
    r = '0;
    r.reported_id = t.endpoint_id;
    why = mta_pkg::R_NONE;
    hit = -1;
    if (t.first_of_plan) begin
      plan_id_count = 0;
      batch_total = 0;
      admit_total = '0;
      drop_total = '0;
    end
    if (!t.eligible) begin
      why = mta_pkg::R_OFFLINE;
      r.reported_id = t.session_id;
    end else if (!t.has_endpoint) begin
      why = mta_pkg::R_INVALID;
      r.reported_id = '0;
    end else begin
      for (i = 0; i < plan_id_count; i++) begin
        if (plan_ids[i] == t.endpoint_id) hit = i;
      end
      // Budgets are checked against the payload times the count after admission,
      // in the divided form so that nothing overflows.
      slot = 64'(admit_total) + 64'd1;
      if (hit >= 0) begin
        why = mta_pkg::R_DUP;
      end else if (plan_id_count >= SEEN_DEPTH) begin
        why = mta_pkg::R_FULL;
      end else begin
        plan_ids[plan_id_count] = t.endpoint_id;
        plan_id_count++;
        if (admit_total >= lim_hard_fanout || admit_total >= MAX_FANOUT) begin
          why = mta_pkg::R_FANOUT;
        end else if (64'(t.payload_bytes) > {32'd0, lim_hard_bytes} / slot) begin
          why = mta_pkg::R_BYTES;
        end else if (t.low_priority && (admit_total >= lim_soft_fanout ||
                     64'(t.payload_bytes) > {32'd0, lim_soft_bytes} / slot)) begin
          why = mta_pkg::R_SOFT;
        end else if (!t.owner_available) begin
          why = mta_pkg::R_OWNER;
        end else if (!t.endpoint_open) begin
          why = mta_pkg::R_CLOSED;
        end
      end
    end
    r.drop_reason = why;
    if (why != mta_pkg::R_NONE) begin
      if (drop_total != '1) drop_total++;
    end else begin
      // Batches are keyed by owner and numbered in order of first appearance.
      hit = -1;
      for (i = 0; i < batch_total; i++) begin
        if (batch_owner_ids[i] == t.owner_id) hit = i;
      end
      if (hit < 0) begin
        hit = batch_total;
        batch_owner_ids[batch_total] = t.owner_id;
        batch_total++;
        r.new_batch = 1'b1;
      end
      r.admitted = 1'b1;
      r.batch_index = mta_pkg::BIDX_W'(hit);
      admit_total++;
    end
    r.accepted_count = admit_total;
    r.dropped_count = drop_total;
    return r;
  endfunction

  // A well-formed target that passes every check unless a limit stops it.
  function automatic mta_pkg::in_item_t make_target(input bit first,
                                                    input logic [31:0] payload,
                                                    input bit low, input logic [63:0] eid,
                                                    input logic [63:0] owner);
    mta_pkg::in_item_t t;
    t = '0;
    t.first_of_plan = first;
    t.payload_bytes = payload;
    t.low_priority = low;
    t.eligible = 1'b1;
    t.has_endpoint = 1'b1;
    t.endpoint_id = eid;
    t.owner_available = 1'b1;
    t.owner_id = owner;
    t.endpoint_open = 1'b1;
    return t;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("MISMATCH %s: expected %h, got %h", what, want, got);
    end
  endtask

  // Called just after a rising edge. Holds back for a random number of cycles, then
  // offers the transaction and keeps it steady until the block takes it. Valid is
  // left high so that a following transaction can go out back to back.
  task automatic send_target(input mta_pkg::in_item_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.insert(pending_results.size(), admit_target(t));
  endtask

  // Stops sending and waits until the block has returned every result it owes.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_limit(input logic [mta_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mta_pkg::CFG_HARD_FANOUT: lim_hard_fanout = val[mta_pkg::FAN_REG_W-1:0];
      mta_pkg::CFG_SOFT_FANOUT: lim_soft_fanout = val[mta_pkg::FAN_REG_W-1:0];
      mta_pkg::CFG_HARD_BYTES:  lim_hard_bytes = val;
      mta_pkg::CFG_SOFT_BYTES:  lim_soft_bytes = val;
      default: ;
    endcase
  endtask

  // Writes all four limits while the block is idle, then a random value to an
  // index that holds no register.
  task automatic program_limits(input logic [31:0] hf, input logic [31:0] sf,
                                input logic [31:0] hb, input logic [31:0] sb);
    logic [mta_pkg::CFG_IDX_W-1:0] spare;
    wait_for_results();
    spare = mta_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST));
    write_limit(mta_pkg::CFG_HARD_FANOUT, hf);
    write_limit(mta_pkg::CFG_SOFT_FANOUT, sf);
    write_limit(mta_pkg::CFG_HARD_BYTES, hb);
    write_limit(mta_pkg::CFG_SOFT_BYTES, sb);
    write_limit(spare, $urandom());
    cfg_valid <= 1'b0;
  endtask

  // Most drop reasons under the reset limits, with the id fields at their extremes.
  task automatic test_each_reason();
    mta_pkg::in_item_t t;
    t = make_target(1'b1, 32'd0, 1'b0, 64'd0, '1);
    t.eligible = 1'b0;
    t.session_id = '1;
    send_target(t);
    t = make_target(1'b0, 32'd0, 1'b0, 64'd5, '1);
    t.has_endpoint = 1'b0;
    send_target(t);
    send_target(make_target(1'b0, 32'd0, 1'b0, 64'd0, '1));
    send_target(make_target(1'b0, 32'd0, 1'b0, 64'd0, '1));
    send_target(make_target(1'b0, 32'd0, 1'b0, '1, 64'd0));
    // The owner check drops this one after its id is recorded, so the retry
    // right after it is a duplicate.
    t = make_target(1'b0, 32'd0, 1'b0, 64'd7, 64'd3);
    t.owner_available = 1'b0;
    send_target(t);
    send_target(make_target(1'b0, 32'd0, 1'b0, 64'd7, 64'd3));
    t = make_target(1'b0, 32'd0, 1'b0, 64'd8, 64'd3);
    t.endpoint_open = 1'b0;
    send_target(t);
    send_target(make_target(1'b0, '1, 1'b0, 64'd9, 64'd3));
    send_target(make_target(1'b0, 32'd1, 1'b1, 64'd10, '1));
    send_target(make_target(1'b0, 32'd1, 1'b0, 64'd11, 64'd0));
    // A new plan forgets every id and batch of the last one.
    send_target(make_target(1'b1, 32'd0, 1'b0, 64'd0, 64'hA5A5_5A5A_0F0F_F0F0));
    send_target(make_target(1'b0, 32'h8000_0000, 1'b0, 64'd12, 64'd1));
    send_target(make_target(1'b0, 32'h7FFF_FFFF, 1'b0, 64'd13, 64'd1));
  endtask

  // Hard and soft limits, zero limits, masked writes and soft limits above hard ones.
  task automatic test_limit_registers();
    program_limits(32'd2, 32'd1, 32'd100, 32'd40);
    send_target(make_target(1'b1, 32'd30, 1'b1, 64'd1, 64'd1));
    send_target(make_target(1'b0, 32'd30, 1'b1, 64'd2, 64'd1));
    send_target(make_target(1'b0, 32'd30, 1'b0, 64'd3, 64'd2));
    send_target(make_target(1'b0, 32'd30, 1'b0, 64'd4, 64'd2));
    send_target(make_target(1'b1, 32'd60, 1'b1, 64'd1, 64'd1));
    send_target(make_target(1'b1, 32'd101, 1'b0, 64'd2, 64'd1));
    send_target(make_target(1'b0, 32'd100, 1'b0, 64'd3, 64'd1));
    // Only the low seven bits land in the fanout register, leaving it at zero.
    program_limits(32'hFFFF_FF80, 32'd64, 32'd0, 32'd0);
    send_target(make_target(1'b1, 32'd0, 1'b0, 64'd1, 64'd1));
    program_limits(32'd64, 32'd0, 32'd0, '1);
    send_target(make_target(1'b1, 32'd0, 1'b0, 64'd1, 64'd1));
    send_target(make_target(1'b0, 32'd1, 1'b0, 64'd2, 64'd1));
    send_target(make_target(1'b0, 32'd0, 1'b1, 64'd3, 64'd1));
    program_limits(32'd5, '1, 32'd1000, '1);
    send_target(make_target(1'b1, 32'd10, 1'b1, 64'd1, 64'd1));
    send_target(make_target(1'b0, 32'd10, 1'b1, 64'd2, 64'd9));
  endtask

  // With the fanout register above the block's capacity, admission still stops at
  // the capacity. Each target brings its own owner, so every batch index is used.
  task automatic test_fanout_capacity();
    int k;
    program_limits('1, '1, '1, '1);
    for (k = 0; k < MAX_FANOUT + 2; k++) begin
      send_target(make_target(k == 0, 32'd0, 1'b0, 64'(k) + 64'd100, 64'(k)));
    end
  endtask

  // Fills the id table: the first targets are admitted, the rest drop on fanout but
  // still record their ids, and new ids past the table's depth report a full table.
  // A repeated id is still a duplicate once the table is full.
  task automatic test_id_table_full();
    logic [63:0] base;
    int k;
    base = rand64();
    program_limits(32'd64, 32'd64, '1, '1);
    for (k = 0; k < SEEN_DEPTH + 2; k++) begin
      send_target(make_target(k == 0, 32'd16, 1'b0, base + 64'(k), 64'(k % 5)));
    end
    send_target(make_target(1'b0, 32'd16, 1'b0, base + 64'd3, 64'd0));
  endtask

  // Random plans under four idling patterns, each with its own limits. Most targets
  // are well formed, with endpoint ids drawn from a pool just larger than the plan so
  // that duplicates turn up, and owners from a small pool so that batches are shared.
  // A few percent are pure noise, and now and then a plan restarts midway.
  task automatic test_random_traffic();
    int idle_by_phase[4] = '{0, 46, 0, 33};
    int stall_by_phase[4] = '{0, 0, 46, 33};
    mta_pkg::in_item_t t;
    logic [255:0] noise;
    logic [63:0] id_base;
    logic [63:0] owner_base;
    logic [31:0] payload;
    logic [31:0] hf;
    logic [31:0] hb;
    bit low;
    int ph;
    int plan_len;
    int sent;
    int k;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: program_limits(32'd64, 32'd64, '1, '1);
        1: begin
          hf = $urandom_range(64, 1);
          hb = $urandom();
          program_limits(hf, $urandom_range(hf, 0), hb, $urandom_range(hb, 0));
        end
        2: program_limits('1, $urandom(), $urandom_range(200000, 0), $urandom());
        default: program_limits($urandom_range(16, 1), $urandom_range(127, 0), '1,
                                $urandom_range(50000, 0));
      endcase
      idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        if ($urandom_range(99) < 4) wait_for_results();
        plan_len = ($urandom_range(9) == 0) ? $urandom_range(140, 60) : $urandom_range(24, 1);
        low = 1'($urandom_range(1));
        case ($urandom_range(3))
          0: payload = 32'd0;
          1: payload = $urandom();
          default: payload = $urandom_range(2000, 0);
        endcase
        id_base = rand64();
        owner_base = rand64();
        for (k = 0; k < plan_len && sent < RANDOM_PER_PHASE; k++) begin
          t.first_of_plan = (k == 0) || ($urandom_range(99) < 2);
          t.payload_bytes = payload;
          t.low_priority = low;
          t.eligible = ($urandom_range(99) < 95);
          t.session_id = rand64();
          t.has_endpoint = ($urandom_range(99) < 95);
          t.endpoint_id = id_base + 64'($urandom_range(plan_len + plan_len / 4, 0));
          t.owner_available = ($urandom_range(99) < 92);
          t.owner_id = ($urandom_range(99) < 10) ? rand64() :
                       owner_base + 64'($urandom_range(7, 0));
          t.endpoint_open = ($urandom_range(99) < 92);
          if (k != 0 && $urandom_range(99) < 5) begin
            noise = {rand64(), rand64(), rand64(), rand64()};
            t = noise[$bits(mta_pkg::in_item_t)-1:0];
          end
          send_target(t);
          sent++;
        end
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  // Each result the block hands over is compared field by field with the oldest
  // expectation.
  always @(posedge clk) begin : check_results
    mta_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, reported_id", '0, out_data.reported_id);
      end else begin
        want = pending_results.pop_front();
        if (out_data.admitted !== want.admitted)
          flag_mismatch("admitted", 64'(want.admitted), 64'(out_data.admitted));
        if (out_data.drop_reason !== want.drop_reason)
          flag_mismatch("drop_reason", 64'(want.drop_reason), 64'(out_data.drop_reason));
        if (out_data.reported_id !== want.reported_id)
          flag_mismatch("reported_id", want.reported_id, out_data.reported_id);
        if (out_data.batch_index !== want.batch_index)
          flag_mismatch("batch_index", 64'(want.batch_index), 64'(out_data.batch_index));
        if (out_data.new_batch !== want.new_batch)
          flag_mismatch("new_batch", 64'(want.new_batch), 64'(out_data.new_batch));
        if (out_data.accepted_count !== want.accepted_count)
          flag_mismatch("accepted_count", 64'(want.accepted_count),
                        64'(out_data.accepted_count));
        if (out_data.dropped_count !== want.dropped_count)
          flag_mismatch("dropped_count", 64'(want.dropped_count),
                        64'(out_data.dropped_count));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_each_reason();
    test_limit_registers();
    test_fanout_capacity();
    test_id_table_full();
    test_random_traffic();
    wait_for_results();
    // Anything the block produces after this point is a result nobody asked for.
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatch_count += pending_results.size();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // A hung handshake ends the run here instead of running forever.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
